### design/three_wire_serial_master_assert.svh
// assertion macros for the three-wire serial master
`ifndef THREE_WIRE_SERIAL_MASTER_ASSERT_SVH
`define THREE_WIRE_SERIAL_MASTER_ASSERT_SVH

`ifndef SYNTHESIS

// condition must hold in the same cycle as the trigger
`define TWS_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition must hold in the cycle after the trigger
`define TWS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define TWS_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons)
`define TWS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

### design/tws_pkg.sv
// shared types and constants for the three-wire serial master
package tws_pkg;

  localparam int HalfWidth = 10;
  localparam logic [HalfWidth-1:0] HALF_RESET = 10'd10;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_BEGIN = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_END   = 3'd4;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_FRAME   = 3'd1,
    M_WR_LOW  = 3'd2,
    M_WR_HIGH = 3'd3,
    M_RD_HIGH = 3'd4,
    M_RD_LOW  = 3'd5
  } mode_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] byte_in;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       sclk;
    logic       ce;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       byte_done;
    logic [7:0] read_byte;
    logic       rejected;
  } res_t;

  typedef struct packed {
    mode_t                mode;
    logic [3:0]           bit_index;
    logic [HalfWidth-1:0] half_timer;
    logic [7:0]           shifter;
    logic                 clock_level;
    logic                 enable_level;
    logic                 data_level;
    logic                 drive_enable;
    logic [7:0]           last_read;
  } state_t;

  function automatic logic is_busy(mode_t m);
    return (m == M_WR_LOW) || (m == M_WR_HIGH) || (m == M_RD_HIGH) || (m == M_RD_LOW);
  endfunction

endpackage

### design/tws_step.sv
// next-state and result logic for one tick of the serial master
module tws_step import tws_pkg::*; (
  input  state_t               st,
  input  req_t                 req,
  input  logic [HalfWidth-1:0] half_period,
  output state_t               st_next,
  output res_t                 res
);

  logic [HalfWidth-1:0] per;
  logic                 done;
  logic                 rej;
  logic                 last_bit;

  always_comb begin
    per      = (half_period == '0) ? {{(HalfWidth-1){1'b0}}, 1'b1} : half_period;
    st_next  = st;
    done     = 1'b0;
    rej      = 1'b0;
    last_bit = (st.bit_index >= 4'd7);

    if (is_busy(st.mode)) begin
      if (req.op >= OP_BEGIN && req.op <= OP_END) begin
        rej = 1'b1;
      end
      if (st.half_timer > {{(HalfWidth-1){1'b0}}, 1'b1}) begin
        st_next.half_timer = st.half_timer - {{(HalfWidth-1){1'b0}}, 1'b1};
      end else begin
        st_next.half_timer = '0;
        unique case (st.mode)
          M_WR_LOW: begin
            st_next.clock_level = 1'b1;
            st_next.mode        = M_WR_HIGH;
            st_next.half_timer  = per;
          end
          M_WR_HIGH: begin
            st_next.shifter   = {1'b0, st.shifter[7:1]};
            st_next.bit_index = st.bit_index + 4'd1;
            if (last_bit) begin
              st_next.mode = M_FRAME;
              done         = 1'b1;
            end else begin
              st_next.data_level  = st.shifter[1];
              st_next.clock_level = 1'b0;
              st_next.mode        = M_WR_LOW;
              st_next.half_timer  = per;
            end
          end
          M_RD_HIGH: begin
            st_next.clock_level = 1'b0;
            st_next.mode        = M_RD_LOW;
            st_next.half_timer  = per;
          end
          M_RD_LOW: begin
            // sampled bit enters at the top, lsb-first assembly
            st_next.shifter   = {req.sda_in, st.shifter[7:1]};
            st_next.bit_index = st.bit_index + 4'd1;
            if (last_bit) begin
              st_next.last_read = {req.sda_in, st.shifter[7:1]};
              st_next.mode      = M_FRAME;
              done              = 1'b1;
            end else begin
              st_next.clock_level = 1'b1;
              st_next.mode        = M_RD_HIGH;
              st_next.half_timer  = per;
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      case (req.op)
        OP_BEGIN, OP_WRITE: begin
          if (req.op == OP_BEGIN || st.mode == M_FRAME) begin
            if (req.op == OP_BEGIN) begin
              st_next.enable_level = 1'b1;
            end
            st_next.shifter      = req.byte_in;
            st_next.bit_index    = 4'd0;
            st_next.drive_enable = 1'b1;
            st_next.data_level   = req.byte_in[0];
            st_next.clock_level  = 1'b0;
            st_next.mode         = M_WR_LOW;
            st_next.half_timer   = per;
          end else begin
            rej = 1'b1;
          end
        end
        OP_READ: begin
          if (st.mode == M_FRAME) begin
            st_next.shifter      = 8'd0;
            st_next.bit_index    = 4'd0;
            st_next.drive_enable = 1'b0;
            st_next.clock_level  = 1'b1;
            st_next.mode         = M_RD_HIGH;
            st_next.half_timer   = per;
          end else begin
            rej = 1'b1;
          end
        end
        OP_END: begin
          st_next.clock_level  = 1'b1;
          st_next.enable_level = 1'b0;
          st_next.drive_enable = 1'b0;
          st_next.mode         = M_IDLE;
          done                 = 1'b1;
        end
        default: begin
        end
      endcase
    end

    res.sclk      = st_next.clock_level;
    res.ce        = st_next.enable_level;
    res.sda_out   = st_next.data_level;
    res.sda_drive = st_next.drive_enable;
    res.busy_res  = is_busy(st_next.mode);
    res.byte_done = done;
    res.read_byte = st_next.last_read;
    res.rejected  = rej;
  end

endmodule

### design/three_wire_serial_master.sv
// top level of the tick-driven three-wire serial master
// - each request on the in channel is one tick of the pin sequencer; it may
//   carry an op (begin frame with command byte, write byte, read byte, end
//   frame) or just advance time
// - every request yields exactly one result on the out channel holding the
//   line levels after that tick, busy, byte_done, the last read byte and a
//   rejected flag
// - both channels use valid/stall; a request is taken when in_valid is high
//   and in_stall is low, a result when out_valid is high and out_stall is low
// - the result is registered: the result of a request taken at one edge is on
//   out_data from the next cycle on
// - throughput is one request per cycle unless a result waits under out_stall;
//   a tick is one pass of the step logic, sequencer state to result register
// - when the receiver stalls, the result register holds; a new request is
//   still taken in the cycle the held result drains, so in_stall only rises
//   while a result waits under out_stall
// - reset (synchronous, active high) idles the sequencer with clock high,
//   chip enable low, data line released, and half period back to 10 ticks
// - cfg_wdata is written to the half period on any edge with cfg_wen high;
//   it takes effect when the next clock phase is loaded
`include "three_wire_serial_master_assert.svh"

module three_wire_serial_master import tws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [HalfWidth-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  req_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output res_t                 out_data
);

  // sequencer state and half-period setting
  state_t               st;
  state_t               st_next;
  logic [HalfWidth-1:0] half_period;
  res_t                 res;
  logic                 in_take;

  // result slot is free when empty or draining this cycle
  assign in_stall = out_valid & out_stall;
  assign in_take  = in_valid & ~in_stall;

  tws_step u_step (
    .st          (st),
    .req         (in_data),
    .half_period (half_period),
    .st_next     (st_next),
    .res         (res)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_RESET;
    end else if (cfg_wen) begin
      half_period <= cfg_wdata;
    end
  end

  // sequencer state advances only on a taken request
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode         <= M_IDLE;
      st.bit_index    <= 4'd0;
      st.half_timer   <= '0;
      st.shifter      <= 8'd0;
      st.clock_level  <= 1'b1;
      st.enable_level <= 1'b0;
      st.data_level   <= 1'b0;
      st.drive_enable <= 1'b0;
      st.last_read    <= 8'd0;
    end else if (in_take) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data <= res;
    end
  end

  // a shift phase always has time left on its timer
  `TWS_ASSERT_SAME(a_busy_timer, clk, rst, is_busy(st.mode), st.half_timer != '0)
  // a byte in flight never runs past its last bit
  `TWS_ASSERT_SAME(a_busy_bits, clk, rst, is_busy(st.mode), st.bit_index < 4'd8)
  // shifting only happens inside a frame
  `TWS_ASSERT_SAME(a_enable_frame, clk, rst, !st.enable_level, st.mode == M_IDLE)
  // the data line is released while reading
  `TWS_ASSERT_SAME(a_read_release, clk, rst,
    st.mode == M_RD_HIGH || st.mode == M_RD_LOW, !st.drive_enable)
  // a taken end request leaves the lines idle
  `TWS_ASSERT_NEXT(a_end_idle, clk, rst, in_take && in_data.op == OP_END && !is_busy(st.mode),
    st.mode == M_IDLE && st.clock_level && out_valid && out_data.byte_done)

endmodule

### bench/three_wire_serial_master_tb.sv
// self-checking testbench for the three-wire serial master: directed and random ticks
module three_wire_serial_master_tb;
  import tws_pkg::*;

  // op codes the block treats as a bare tick
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  localparam int RANDOM_REQUESTS = 600;
  localparam int IDLE_LIMIT      = 2000;  // cycles with no handshake before giving up
  localparam int SETTLE_CYCLES   = 8;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wen;
  logic [HalfWidth-1:0] cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  req_t                 in_data;
  logic                 out_valid;
  logic                 out_stall;
  res_t                 out_data;

  three_wire_serial_master i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // shadow of the pin sequencer, advanced once per accepted request
  mode_t                seq_mode;
  logic [3:0]           bits_done;
  logic [HalfWidth-1:0] phase_left;
  logic [7:0]           shreg;
  logic                 sclk_lvl;
  logic                 ce_lvl;
  logic                 sda_lvl;
  logic                 drive_lvl;
  logic [7:0]           rx_byte;
  logic [HalfWidth-1:0] half_period;

  res_t line_levels_q[$];  // predicted line levels, oldest first
  int   fail_count = 0;
  int   items_sent = 0;
  int   calm_left  = 0;    // requests still to go with no sender gap
  int   idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic shifting();
    return seq_mode == M_WR_LOW || seq_mode == M_WR_HIGH ||
           seq_mode == M_RD_HIGH || seq_mode == M_RD_LOW;
  endfunction

  // a zero half period behaves like one tick
  function automatic logic [HalfWidth-1:0] phase_len();
    return (half_period == '0) ? 10'd1 : half_period;
  endfunction

  // put bit 0 on the data line with the clock low
  function automatic void load_byte_out(logic [7:0] b);
    shreg      = b;
    bits_done  = '0;
    drive_lvl  = 1'b1;
    sda_lvl    = b[0];
    sclk_lvl   = 1'b0;
    seq_mode   = M_WR_LOW;
    phase_left = phase_len();
  endfunction

  // line levels after one tick, updating the shadow state
  function automatic res_t advance_lines(req_t r);
    res_t o;
    logic done;
    logic rej;
    done = 1'b0;
    rej  = 1'b0;
    if (shifting()) begin
      // any real request during a shift is refused, the shift carries on
      if (r.op >= OP_BEGIN && r.op <= OP_END) rej = 1'b1;
      if (phase_left > 10'd1) begin
        phase_left = phase_left - 10'd1;
      end else begin
        phase_left = '0;
        case (seq_mode)
          M_WR_LOW: begin
            sclk_lvl   = 1'b1;
            seq_mode   = M_WR_HIGH;
            phase_left = phase_len();
          end
          M_WR_HIGH: begin
            shreg     = shreg >> 1;
            bits_done = bits_done + 4'd1;
            if (bits_done >= 4'd8) begin
              seq_mode = M_FRAME;
              done     = 1'b1;
            end else begin
              sda_lvl    = shreg[0];
              sclk_lvl   = 1'b0;
              seq_mode   = M_WR_LOW;
              phase_left = phase_len();
            end
          end
          M_RD_HIGH: begin
            sclk_lvl   = 1'b0;
            seq_mode   = M_RD_LOW;
            phase_left = phase_len();
          end
          default: begin
            // sampled bit enters at the top, lsb first on the wire
            shreg     = {r.sda_in, shreg[7:1]};
            bits_done = bits_done + 4'd1;
            if (bits_done >= 4'd8) begin
              rx_byte  = shreg;
              seq_mode = M_FRAME;
              done     = 1'b1;
            end else begin
              sclk_lvl   = 1'b1;
              seq_mode   = M_RD_HIGH;
              phase_left = phase_len();
            end
          end
        endcase
      end
    end else begin
      case (r.op)
        OP_BEGIN: begin
          // also restarts an open frame
          ce_lvl = 1'b1;
          load_byte_out(r.byte_in);
        end
        OP_WRITE: begin
          if (seq_mode == M_FRAME) load_byte_out(r.byte_in);
          else rej = 1'b1;
        end
        OP_READ: begin
          if (seq_mode == M_FRAME) begin
            shreg      = '0;
            bits_done  = '0;
            drive_lvl  = 1'b0;
            sclk_lvl   = 1'b1;
            seq_mode   = M_RD_HIGH;
            phase_left = phase_len();
          end else begin
            rej = 1'b1;
          end
        end
        OP_END: begin
          // accepted even with no frame open
          sclk_lvl  = 1'b1;
          ce_lvl    = 1'b0;
          drive_lvl = 1'b0;
          seq_mode  = M_IDLE;
          done      = 1'b1;
        end
        default: begin
        end
      endcase
    end
    o.sclk      = sclk_lvl;
    o.ce        = ce_lvl;
    o.sda_out   = sda_lvl;
    o.sda_drive = drive_lvl;
    o.busy_res  = shifting();
    o.byte_done = done;
    o.read_byte = rx_byte;
    o.rejected  = rej;
    return o;
  endfunction

  // offer one request, hold it until taken, then record its prediction
  task automatic send_req(input logic [2:0] op, input logic [7:0] data_byte, input logic sda);
    req_t r;
    int   gap;
    int   roll;
    r.op      = op;
    r.byte_in = data_byte;
    r.sda_in  = sda;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) calm_left = $urandom_range(20, 80);
      else if (roll < 45) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 96) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 50);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    line_levels_q.push_back(advance_lines(r));
    items_sent++;
  endtask

  // sender holds off until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (line_levels_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_half_period(input logic [HalfWidth-1:0] v);
    drain_results();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen     <= 1'b0;
    half_period  = v;
  endtask

  // tick until the byte in flight is done; reads see rx_pattern on the data line
  task automatic finish_shift(input logic [7:0] rx_pattern);
    int         roll;
    logic [2:0] op;
    while (shifting()) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) op = OP_TICK;
      else if (roll < 90) op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      else op = 3'($urandom_range(OP_BEGIN, OP_END));  // refused while busy
      send_req(op, 8'($urandom), rx_pattern[bits_done[2:0]]);
    end
  endtask

  // no frame open: ticks, spare codes, data requests refused, end still taken;
  // then one frame at the reset half period
  task automatic test_idle_requests();
    logic [2:0] op;
    send_req(OP_TICK, 8'h00, 1'b0);
    for (op = OP_SPARE_FIRST; op != OP_TICK; op++) send_req(op, 8'hFF, 1'b1);
    send_req(OP_WRITE, 8'hFF, 1'b1);
    send_req(OP_READ, 8'h00, 1'b0);
    send_req(OP_END, 8'h00, 1'b0);
    send_req(OP_BEGIN, 8'hB1, 1'b0);
    finish_shift(8'h00);
    send_req(OP_END, 8'h00, 1'b0);
  endtask

  // write extremes and a begin that restarts an open frame
  task automatic test_write_bytes();
    set_half_period(10'd1);
    send_req(OP_BEGIN, 8'hFF, 1'b0);
    finish_shift(8'h00);
    send_req(OP_WRITE, 8'h00, 1'b1);
    finish_shift(8'hFF);
    send_req(OP_WRITE, 8'hA5, 1'b0);
    finish_shift(8'h00);
    send_req(OP_BEGIN, 8'h5A, 1'b1);
    finish_shift(8'h00);
    send_req(OP_END, 8'h00, 1'b0);
  endtask

  // read patterns, then a read after the frame closed
  task automatic test_read_bytes();
    set_half_period(10'd2);
    send_req(OP_BEGIN, 8'h81, 1'b0);
    finish_shift(8'h00);
    send_req(OP_READ, 8'h00, 1'b1);
    finish_shift(8'hFF);
    send_req(OP_READ, 8'hFF, 1'b0);
    finish_shift(8'h00);
    send_req(OP_READ, 8'h00, 1'b0);
    finish_shift(8'h3C);
    send_req(OP_END, 8'h00, 1'b0);
    send_req(OP_READ, 8'h00, 1'b1);
  endtask

  task automatic test_zero_half_period();
    set_half_period(10'd0);
    send_req(OP_BEGIN, 8'h0F, 1'b0);
    finish_shift(8'h00);
    send_req(OP_READ, 8'h00, 1'b0);
    finish_shift(8'hC6);
    send_req(OP_END, 8'h00, 1'b0);
  endtask

  // new half period lands mid byte and applies from the next phase
  task automatic test_period_change_mid_byte();
    set_half_period(10'd3);
    send_req(OP_BEGIN, 8'hC3, 1'b0);
    repeat (5) send_req(OP_TICK, 8'($urandom), 1'($urandom));
    set_half_period(10'd7);
    finish_shift(8'h00);
    send_req(OP_READ, 8'h00, 1'b0);
    repeat (9) send_req(OP_TICK, 8'($urandom), 1'($urandom));
    set_half_period(10'd2);
    finish_shift(8'h69);
    send_req(OP_END, 8'h00, 1'b0);
  endtask

  // mostly well formed frames with random content, some noise and open frames
  task automatic test_random_traffic(input int n);
    int         stop_at;
    int         roll;
    logic [2:0] op;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) set_half_period(10'($urandom_range(1, 3)));
        else if (roll < 88) set_half_period(10'($urandom_range(4, 8)));
        else if (roll < 94) set_half_period(10'd0);
        else set_half_period(10'($urandom_range(9, 24)));
      end else if (roll < 20) begin
        send_req(3'($urandom_range(OP_TICK, OP_SPARE_LAST)), 8'($urandom), 1'($urandom));
        finish_shift(8'($urandom));
      end else begin
        send_req(OP_BEGIN, 8'($urandom), 1'($urandom));
        finish_shift(8'($urandom));
        repeat ($urandom_range(0, 4)) begin
          op = ($urandom_range(0, 1) == 0) ? OP_WRITE : OP_READ;
          send_req(op, 8'($urandom), 1'($urandom));
          finish_shift(8'($urandom));
        end
        if ($urandom_range(0, 99) < 85) send_req(OP_END, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // receiver: calm stretches, short stalls, occasional long ones
  initial begin
    int roll;
    int len;
    out_stall <= 1'b0;
    forever begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        out_stall <= 1'b0;
        len = $urandom_range(10, 60);
      end else if (roll < 65) begin
        out_stall <= 1'b1;
        len = $urandom_range(1, 2);
      end else if (roll < 90) begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 4);
      end else if (roll < 97) begin
        out_stall <= 1'b1;
        len = $urandom_range(3, 10);
      end else begin
        out_stall <= 1'b1;
        len = $urandom_range(20, 50);
      end
      repeat (len) @(posedge clk);
    end
  end

  task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      fail_count++;
    end
  endtask

  // every result taken is matched against the oldest prediction
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (line_levels_q.size() == 0) begin
        $error("result with no request outstanding: %h", out_data);
        fail_count++;
      end else begin
        want = line_levels_q.pop_front();
        check_field("sclk", 8'(want.sclk), 8'(out_data.sclk));
        check_field("ce", 8'(want.ce), 8'(out_data.ce));
        check_field("sda_out", 8'(want.sda_out), 8'(out_data.sda_out));
        check_field("sda_drive", 8'(want.sda_drive), 8'(out_data.sda_drive));
        check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
        check_field("byte_done", 8'(want.byte_done), 8'(out_data.byte_done));
        check_field("read_byte", want.read_byte, out_data.read_byte);
        check_field("rejected", 8'(want.rejected), 8'(out_data.rejected));
      end
    end
  end

  // watchdog on handshakes in either direction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("three_wire_serial_master verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    // shadow state after reset: clock high, chip enable low, line released
    seq_mode    = M_IDLE;
    bits_done   = '0;
    phase_left  = '0;
    shreg       = '0;
    sclk_lvl    = 1'b1;
    ce_lvl      = 1'b0;
    sda_lvl     = 1'b0;
    drive_lvl   = 1'b0;
    rx_byte     = '0;
    half_period = HALF_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_idle_requests();
    test_write_bytes();
    test_read_bytes();
    test_zero_half_period();
    test_period_change_mid_byte();
    test_random_traffic(RANDOM_REQUESTS);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("three_wire_serial_master verification clean");
    end else begin
      $display("three_wire_serial_master verification failed");
    end
    $finish;
  end

endmodule
